@@ design/aipid_pkg.sv @@
// ----------------------------------------------------------------------------
// aipid_pkg
// Shared types and constants for the averaged incremental PID servo core.
// ----------------------------------------------------------------------------
package aipid_pkg;

  // Field widths
  localparam int POS_W    = 10;
  localparam int ERR_W    = 11;
  localparam int GAIN_W   = 16;
  localparam int BAND_W   = 8;
  localparam int BUDGET_W = 24;
  localparam int LOCK_W   = 16;
  localparam int DRIVE_W  = 13;
  localparam int ACC_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_BAND     = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST        = 16'd100;
  localparam logic [GAIN_W-1:0] GAIN_I_RST        = 16'd15;
  localparam logic [GAIN_W-1:0] GAIN_D_RST        = 16'd0;
  localparam logic [POS_W-1:0]  TARGET_CENTER_RST = 10'd80;
  localparam logic [BAND_W-1:0] LOCK_BAND_RST     = 8'd3;

  // Position code that marks a tick without a tracked target
  localparam logic [POS_W-1:0] NO_TARGET = 10'd999;

  // Accumulator holds drive in 1/10000 count units, clamped to 6000 counts
  localparam logic [ACC_W-1:0] ACC_MAX = 26'd60000000;

  // drive = acc / 10000 = (acc >> 4) / 625, done as a multiply by ceil(2^32/625)
  localparam int ACC_DROP     = 4;
  localparam int DRV_X_W      = ACC_W - ACC_DROP;
  localparam int DRV_RECIP_W  = 23;
  localparam int DRV_SHIFT    = 32;
  localparam int DRV_PROD_W   = DRV_X_W + DRV_RECIP_W;
  localparam logic [DRV_RECIP_W-1:0] DRV_RECIP = 23'd6871948;

  // PID products: 18 bit unsigned gain sum times 11 bit signed error
  localparam int KSUM_W = GAIN_W + 2;
  localparam int PROD_W = KSUM_W + 1 + ERR_W - 1;
  localparam int INC_W  = PROD_W + 2;
  localparam int ACC_SUM_W = INC_W + 1;

  // Per-word operation, decided when the word is taken
  typedef enum logic [1:0] {
    OP_ARM,
    OP_EXPIRED,
    OP_HOLD,
    OP_UPDATE
  } op_t;

endpackage

@@ design/averaged_incremental_pid_servo_core.sv @@
// ----------------------------------------------------------------------------
// averaged_incremental_pid_servo_core
// One-axis servo: arm words load a tick budget and lock countdown, tick words
// feed a windowed error average into an incremental PID drive accumulator.
// ----------------------------------------------------------------------------
// The core takes one word per cycle while the output side does not stall, and
// returns one result word per input word. The error window lives in a RAM that
// is read at the window head in the cycle a word is taken and rewritten there
// when the word updates the average; the window sum, error history, lock
// countdown and drive accumulator each update in a single pipeline stage, so
// consecutive words never wait on one another. Window entries not yet written
// read as zero. Configuration writes are registered and belong between
// bursts of traffic, once every taken word has delivered its result.
module averaged_incremental_pid_servo_core #(
  parameter int WINDOW_LENGTH = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [aipid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aipid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [aipid_pkg::POS_W-1:0]         in_target_position,
  input  logic [aipid_pkg::BUDGET_W-1:0]      in_tick_budget,
  input  logic [aipid_pkg::LOCK_W-1:0]        in_lock_count,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aipid_pkg::DRIVE_W-1:0]       out_drive,
  output logic                                out_drive_updated,
  output logic signed [aipid_pkg::ERR_W-1:0]  out_averaged_error,
  output logic [aipid_pkg::LOCK_W-1:0]        out_lock_remaining,
  output logic [aipid_pkg::BUDGET_W-1:0]      out_budget_remaining
);

  localparam int ERR_W    = aipid_pkg::ERR_W;
  localparam int LOCK_W   = aipid_pkg::LOCK_W;
  localparam int BUDGET_W = aipid_pkg::BUDGET_W;
  localparam int AW       = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int MAG_W    = $clog2(WINDOW_LENGTH * 1024);
  localparam int SUM_W    = MAG_W + 1;
  localparam int DIV_SH   = MAG_W + $clog2(WINDOW_LENGTH) + 1;
  localparam int RECIP_W  = DIV_SH + 1;
  localparam int DPROD_W  = MAG_W + RECIP_W;
  localparam int unsigned RECIP_I =
      ((32'd1 << DIV_SH) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
  localparam logic [AW-1:0] HEAD_LAST = AW'(WINDOW_LENGTH - 1);
  localparam int PROD_W    = aipid_pkg::PROD_W;
  localparam int INC_W     = aipid_pkg::INC_W;
  localparam int ACC_SUM_W = aipid_pkg::ACC_SUM_W;
  localparam int KSUM_W    = aipid_pkg::KSUM_W;
  localparam int ACC_W     = aipid_pkg::ACC_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [aipid_pkg::GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [aipid_pkg::POS_W-1:0]  center_r;
  logic [aipid_pkg::BAND_W-1:0] band_r;
  logic [KSUM_W-1:0]            k1_r, k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= aipid_pkg::GAIN_P_RST;
      gain_i_r <= aipid_pkg::GAIN_I_RST;
      gain_d_r <= aipid_pkg::GAIN_D_RST;
      center_r <= aipid_pkg::TARGET_CENTER_RST;
      band_r   <= aipid_pkg::LOCK_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aipid_pkg::REG_GAIN_P:        gain_p_r <= cfg_wdata;
        aipid_pkg::REG_GAIN_I:        gain_i_r <= cfg_wdata;
        aipid_pkg::REG_GAIN_D:        gain_d_r <= cfg_wdata;
        aipid_pkg::REG_TARGET_CENTER: center_r <= cfg_wdata[aipid_pkg::POS_W-1:0];
        aipid_pkg::REG_LOCK_BAND:     band_r   <= cfg_wdata[aipid_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Combined PID coefficients, refreshed every cycle from the gains
  always_ff @(posedge clk) begin
    k1_r <= KSUM_W'(gain_p_r) + KSUM_W'(gain_i_r) + KSUM_W'(gain_d_r);
    k2_r <= KSUM_W'(gain_p_r) + {KSUM_W'(gain_d_r), 1'b0}[KSUM_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Handshake chain: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, out_valid_r;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_f, ld_out;
  logic mv_a, mv_b, mv_c, mv_d, mv_e, mv_f;
  logic take;

  assign ld_out = !out_valid_r || out_ready;
  assign mv_f   = f_v_r && ld_out;
  assign ld_f   = !f_v_r || mv_f;
  assign mv_e   = e_v_r && ld_f;
  assign ld_e   = !e_v_r || mv_e;
  assign mv_d   = d_v_r && ld_e;
  assign ld_d   = !d_v_r || mv_d;
  assign mv_c   = c_v_r && ld_d;
  assign ld_c   = !c_v_r || mv_c;
  assign mv_b   = b_v_r && ld_c;
  assign ld_b   = !b_v_r || mv_b;
  assign mv_a   = a_v_r && ld_b;
  assign ld_a   = !a_v_r || mv_a;
  assign in_ready = ld_a;
  assign take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_a)   a_v_r <= take;
      if (ld_b)   b_v_r <= mv_a;
      if (ld_c)   c_v_r <= mv_b;
      if (ld_d)   d_v_r <= mv_c;
      if (ld_e)   e_v_r <= mv_d;
      if (ld_f)   f_v_r <= mv_e;
      if (ld_out) out_valid_r <= mv_f;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: decide the operation, count the budget, access the window RAM
  // --------------------------------------------------------------------------
  logic [BUDGET_W-1:0] tick_r, tick_nxt;
  logic [AW-1:0]       head_r;
  logic                wrapped_r;
  aipid_pkg::op_t      op_nxt;
  logic signed [ERR_W-1:0] err_in;
  logic [ERR_W-1:0]    ram_rdata;
  logic                ram_we;

  aipid_pkg::op_t          a_op_r;
  logic signed [ERR_W-1:0] a_err_r;
  logic [BUDGET_W-1:0]     a_budget_r;
  logic [LOCK_W-1:0]       a_lock_r;
  logic                    a_old_ok_r;

  always_comb begin
    priority if (in_command) begin
      op_nxt = aipid_pkg::OP_ARM;
    end else if (tick_r == '0) begin
      op_nxt = aipid_pkg::OP_EXPIRED;
    end else if (in_target_position == aipid_pkg::NO_TARGET) begin
      op_nxt = aipid_pkg::OP_HOLD;
    end else begin
      op_nxt = aipid_pkg::OP_UPDATE;
    end
  end

  always_comb begin
    unique case (op_nxt)
      aipid_pkg::OP_ARM:     tick_nxt = in_tick_budget;
      aipid_pkg::OP_EXPIRED: tick_nxt = tick_r;
      default:               tick_nxt = tick_r - 1'b1;
    endcase
  end

  assign err_in = $signed({1'b0, in_target_position}) - $signed({1'b0, center_r});
  assign ram_we = take && (op_nxt == aipid_pkg::OP_UPDATE);

  aipid_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (err_in),
    .re    (take),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      head_r    <= '0;
      wrapped_r <= 1'b0;
    end else if (take) begin
      tick_r <= tick_nxt;
      if (ram_we) begin
        if (head_r == HEAD_LAST) begin
          head_r    <= '0;
          wrapped_r <= 1'b1;
        end else begin
          head_r <= head_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op_r     <= op_nxt;
      a_err_r    <= err_in;
      a_budget_r <= tick_nxt;
      a_lock_r   <= in_lock_count;
      a_old_ok_r <= wrapped_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: update the window sum, split into sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] wsum_r, wsum_nxt;
  logic signed [ERR_W-1:0] old_err;
  aipid_pkg::op_t          b_op_r;
  logic [MAG_W-1:0]        b_mag_r;
  logic                    b_neg_r;
  logic [BUDGET_W-1:0]     b_budget_r;
  logic [LOCK_W-1:0]       b_lock_r;

  // an entry never written reads as zero
  assign old_err  = a_old_ok_r ? $signed(ram_rdata) : '0;
  assign wsum_nxt = wsum_r - SUM_W'(old_err) + SUM_W'(a_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
    end else if (mv_a && (a_op_r == aipid_pkg::OP_UPDATE)) begin
      wsum_r <= wsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_a) begin
      b_op_r     <= a_op_r;
      b_neg_r    <= wsum_nxt[SUM_W-1];
      b_mag_r    <= wsum_nxt[SUM_W-1] ? MAG_W'(-wsum_nxt) : MAG_W'(wsum_nxt);
      b_budget_r <= a_budget_r;
      b_lock_r   <= a_lock_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: magnitude / WINDOW_LENGTH by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [DPROD_W-1:0]  div_prod;
  aipid_pkg::op_t      c_op_r;
  logic [ERR_W-1:0]    c_q_r;
  logic                c_neg_r;
  logic [BUDGET_W-1:0] c_budget_r;
  logic [LOCK_W-1:0]   c_lock_r;

  assign div_prod = DPROD_W'(b_mag_r) * DPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (mv_b) begin
      c_op_r     <= b_op_r;
      c_q_r      <= div_prod[DIV_SH +: ERR_W];
      c_neg_r    <= b_neg_r;
      c_budget_r <= b_budget_r;
      c_lock_r   <= b_lock_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: signed average, error history, lock countdown
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0] avg;
  logic signed [ERR_W-1:0] err_now_r, err_prev_r, err_prev2_r;
  logic [LOCK_W-1:0]       lock_r, lock_nxt;
  logic                    in_band;
  aipid_pkg::op_t          d_op_r;
  logic signed [ERR_W-1:0] d_avg_r;
  logic [BUDGET_W-1:0]     d_budget_r;
  logic [LOCK_W-1:0]       d_lock_r;

  // truncate toward zero: negate the magnitude quotient
  assign avg     = c_neg_r ? -$signed(c_q_r) : $signed(c_q_r);
  assign in_band = c_q_r < ERR_W'(band_r);

  always_comb begin
    unique case (c_op_r)
      aipid_pkg::OP_ARM:     lock_nxt = c_lock_r;
      aipid_pkg::OP_EXPIRED: lock_nxt = '0;
      aipid_pkg::OP_UPDATE:  lock_nxt = (in_band && (lock_r != '0)) ? lock_r - 1'b1 : lock_r;
      default:               lock_nxt = lock_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r      <= '0;
      err_now_r   <= '0;
      err_prev_r  <= '0;
      err_prev2_r <= '0;
    end else if (mv_c) begin
      lock_r <= lock_nxt;
      if (c_op_r == aipid_pkg::OP_UPDATE) begin
        err_prev2_r <= err_prev_r;
        err_prev_r  <= err_now_r;
        err_now_r   <= avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv_c) begin
      d_op_r     <= c_op_r;
      d_avg_r    <= (c_op_r == aipid_pkg::OP_UPDATE) ? avg : err_now_r;
      d_budget_r <= c_budget_r;
      d_lock_r   <= lock_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: PID products against the history left by this word
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] e_p1_r, e_p2_r, e_p3_r;
  logic                     e_upd_r;
  logic signed [ERR_W-1:0]  e_avg_r;
  logic [BUDGET_W-1:0]      e_budget_r;
  logic [LOCK_W-1:0]        e_lock_r;

  always_ff @(posedge clk) begin
    if (mv_d) begin
      e_p1_r     <= PROD_W'($signed({1'b0, k1_r})) * PROD_W'(err_now_r);
      e_p2_r     <= PROD_W'($signed({1'b0, k2_r})) * PROD_W'(err_prev_r);
      e_p3_r     <= PROD_W'($signed({1'b0, gain_d_r})) * PROD_W'(err_prev2_r);
      e_upd_r    <= (d_op_r == aipid_pkg::OP_UPDATE);
      e_avg_r    <= d_avg_r;
      e_budget_r <= d_budget_r;
      e_lock_r   <= d_lock_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: accumulate and clamp to 0..ACC_MAX
  // --------------------------------------------------------------------------
  localparam logic signed [ACC_SUM_W-1:0] ACC_MAX_S =
      ACC_SUM_W'($signed({1'b0, aipid_pkg::ACC_MAX}));

  logic signed [INC_W-1:0]     inc;
  logic signed [ACC_SUM_W-1:0] acc_sum;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic                        f_upd_r;
  logic signed [ERR_W-1:0]     f_avg_r;
  logic [BUDGET_W-1:0]         f_budget_r;
  logic [LOCK_W-1:0]           f_lock_r;

  assign inc     = INC_W'(e_p1_r) - INC_W'(e_p2_r) + INC_W'(e_p3_r);
  assign acc_sum = ACC_SUM_W'($signed({1'b0, acc_r})) + ACC_SUM_W'(inc);

  always_comb begin
    priority if (acc_sum < 0) begin
      acc_nxt = '0;
    end else if (acc_sum > ACC_MAX_S) begin
      acc_nxt = aipid_pkg::ACC_MAX;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (mv_e && e_upd_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_e) begin
      f_upd_r    <= e_upd_r;
      f_avg_r    <= e_avg_r;
      f_budget_r <= e_budget_r;
      f_lock_r   <= e_lock_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: drive = acc / 10000 by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [aipid_pkg::DRV_PROD_W-1:0] drv_prod;
  logic [aipid_pkg::DRIVE_W-1:0]    out_drive_r;
  logic                             out_upd_r;
  logic signed [ERR_W-1:0]          out_avg_r;
  logic [LOCK_W-1:0]                out_lock_r;
  logic [BUDGET_W-1:0]              out_budget_r;

  assign drv_prod = aipid_pkg::DRV_PROD_W'(acc_r[ACC_W-1:aipid_pkg::ACC_DROP])
                  * aipid_pkg::DRV_PROD_W'(aipid_pkg::DRV_RECIP);

  always_ff @(posedge clk) begin
    if (mv_f) begin
      out_drive_r  <= drv_prod[aipid_pkg::DRV_SHIFT +: aipid_pkg::DRIVE_W];
      out_upd_r    <= f_upd_r;
      out_avg_r    <= f_avg_r;
      out_lock_r   <= f_lock_r;
      out_budget_r <= f_budget_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = out_drive_r;
  assign out_drive_updated    = out_upd_r;
  assign out_averaged_error   = out_avg_r;
  assign out_lock_remaining   = out_lock_r;
  assign out_budget_remaining = out_budget_r;

endmodule

@@ design/aipid_ram.sv @@
// ----------------------------------------------------------------------------
// aipid_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module aipid_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 20
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
